FILE: rtl/jpsd_pkg.sv
package jpsd_pkg;

   // Register indexes of the configuration port.
   localparam logic [2:0] REG_GAIN_PROP   = 3'd0;
   localparam logic [2:0] REG_GAIN_INTEG  = 3'd1;
   localparam logic [2:0] REG_GAIN_DERIV  = 3'd2;
   localparam logic [2:0] REG_TOLERANCE   = 3'd3;
   localparam logic [2:0] REG_CW_FLOOR    = 3'd4;
   localparam logic [2:0] REG_CW_CEILING  = 3'd5;
   localparam logic [2:0] REG_CCW_FLOOR   = 3'd6;
   localparam logic [2:0] REG_CCW_CEILING = 3'd7;

   // Motor command codes.
   localparam logic [1:0] DIR_STOP = 2'd0;
   localparam logic [1:0] DIR_CW   = 2'd1;
   localparam logic [1:0] DIR_CCW  = 2'd2;

   // Q12 fraction bits of the gains.
   localparam int FRAC_BITS = 12;

   // Configuration register set.
   typedef struct packed {
      logic [15:0] gain_prop;
      logic [15:0] gain_integ;
      logic [15:0] gain_deriv;
      logic [15:0] tolerance;
      logic [7:0]  cw_floor;
      logic [7:0]  cw_ceiling;
      logic [7:0]  ccw_floor;
      logic [7:0]  ccw_ceiling;
   } cfg_type;

   typedef struct packed {
      logic signed [31:0] position;
      logic signed [31:0] target;
      logic [15:0]        elapsed_ms;
      logic               limit_fwd;
      logic               limit_rev;
   } req_type;

   typedef struct packed {
      logic [1:0] drive_dir;
      logic [7:0] drive_level;
      logic       brake_on;
      logic       settled;
   } rsp_type;

   // Divider control: start pulse and operands, done and quotient back.
   typedef struct packed {
      logic        start;
      logic [63:0] dividend_mag;
      logic [15:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic        busy;
      logic        done;
      logic [63:0] quotient;
   } div_rsp_type;

endpackage

FILE: rtl/jpsd_if.sv
interface jpsd_req_if import jpsd_pkg::*; ();
   logic    valid;
   logic    ready;
   req_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

interface jpsd_rsp_if import jpsd_pkg::*; ();
   logic    valid;
   logic    ready;
   rsp_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

FILE: rtl/jpsd_div.sv
// Restoring unsigned divider of a 64-bit magnitude by a 16-bit divisor, one
// quotient bit per cycle.
module jpsd_div
   import jpsd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  div_req_type div_req,
   output div_rsp_type div_rsp
);

   logic [63:0] quot_ff, quot_in;
   logic [16:0] rem_ff, rem_in;
   logic [15:0] dsr_ff, dsr_in;
   logic [6:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [16:0] trial;

   // One shift-and-subtract step per cycle.
   always_comb begin
      quot_in = quot_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial   = {rem_ff[15:0], quot_ff[63]};
      if (div_req.start) begin
         quot_in = div_req.dividend_mag;
         rem_in  = '0;
         dsr_in  = div_req.divisor;
         cnt_in  = 7'd64;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial >= {1'b0, dsr_ff}) begin
            rem_in  = trial - {1'b0, dsr_ff};
            quot_in = {quot_ff[62:0], 1'b1};
         end else begin
            rem_in  = trial;
            quot_in = {quot_ff[62:0], 1'b0};
         end
         cnt_in = cnt_ff - 7'd1;
         if (cnt_ff == 7'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      quot_ff <= quot_in;
      rem_ff  <= rem_in;
      dsr_ff  <= dsr_in;
      if (reset) begin
         cnt_ff  <= '0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign div_rsp.busy     = busy_ff;
   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = quot_ff;

   // A finished division never overlaps a running one.
   assert property (@(posedge clock) disable iff (reset) done_ff |-> !busy_ff)
      else $error("divider done while busy");
   assert property (@(posedge clock) disable iff (reset) busy_ff |-> cnt_ff != 7'd0)
      else $error("divider busy with zero count");
   assert property (@(posedge clock) disable iff (reset)
      (busy_ff && cnt_ff == 7'd1 && !div_req.start) |=> done_ff)
      else $error("divider missed done");

endmodule

FILE: rtl/jpsd_csr.sv
// APB-style register file for the gains, tolerance and clamp limits.
module jpsd_csr
   import jpsd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [4:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready,
   output cfg_type     cfg
);

   cfg_type     cfg_ff, cfg_in;
   logic [2:0]  idx;
   logic        wr;

   assign idx    = paddr[4:2];
   assign wr     = psel && penable && pwrite;
   assign pready = 1'b1;

   // Register write decode.
   always_comb begin
      cfg_in = cfg_ff;
      if (wr) begin
         case (idx)
            REG_GAIN_PROP:   cfg_in.gain_prop   = pwdata[15:0];
            REG_GAIN_INTEG:  cfg_in.gain_integ  = pwdata[15:0];
            REG_GAIN_DERIV:  cfg_in.gain_deriv  = pwdata[15:0];
            REG_TOLERANCE:   cfg_in.tolerance   = pwdata[15:0];
            REG_CW_FLOOR:    cfg_in.cw_floor    = pwdata[7:0];
            REG_CW_CEILING:  cfg_in.cw_ceiling  = pwdata[7:0];
            REG_CCW_FLOOR:   cfg_in.ccw_floor   = pwdata[7:0];
            REG_CCW_CEILING: cfg_in.ccw_ceiling = pwdata[7:0];
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   // Read mux.
   always_comb begin
      case (idx)
         REG_GAIN_PROP:   prdata = {16'd0, cfg_ff.gain_prop};
         REG_GAIN_INTEG:  prdata = {16'd0, cfg_ff.gain_integ};
         REG_GAIN_DERIV:  prdata = {16'd0, cfg_ff.gain_deriv};
         REG_TOLERANCE:   prdata = {16'd0, cfg_ff.tolerance};
         REG_CW_FLOOR:    prdata = {24'd0, cfg_ff.cw_floor};
         REG_CW_CEILING:  prdata = {24'd0, cfg_ff.cw_ceiling};
         REG_CCW_FLOOR:   prdata = {24'd0, cfg_ff.ccw_floor};
         REG_CCW_CEILING: prdata = {24'd0, cfg_ff.ccw_ceiling};
         default:         prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.gain_prop   <= 16'd123;
         cfg_ff.gain_integ  <= 16'd82;
         cfg_ff.gain_deriv  <= 16'd2048;
         cfg_ff.tolerance   <= 16'd22;
         cfg_ff.cw_floor    <= 8'd0;
         cfg_ff.cw_ceiling  <= 8'd50;
         cfg_ff.ccw_floor   <= 8'd80;
         cfg_ff.ccw_ceiling <= 8'd150;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

FILE: rtl/jpsd_core.sv
// Sequencer around one shared 34x17 signed multiplier and the serial divider.
module jpsd_core
   import jpsd_pkg::*;
#(
   parameter int MAX_STEP = 15,
   parameter int SUM_BITS = 48
) (
   input  logic  clock,
   input  logic  reset,
   input  cfg_type cfg,
   jpsd_req_if.sink   req,
   jpsd_rsp_if.source rsp
);

   localparam logic [3:0] ST_IDLE  = 4'd0;
   localparam logic [3:0] ST_ERR   = 4'd1;
   localparam logic [3:0] ST_INC   = 4'd2;
   localparam logic [3:0] ST_SUM   = 4'd3;
   localparam logic [3:0] ST_PROP  = 4'd4;
   localparam logic [3:0] ST_ILO   = 4'd5;
   localparam logic [3:0] ST_IHI   = 4'd6;
   localparam logic [3:0] ST_DMUL  = 4'd7;
   localparam logic [3:0] ST_DIV   = 4'd8;
   localparam logic [3:0] ST_DWAIT = 4'd9;
   localparam logic [3:0] ST_TOTAL = 4'd10;
   localparam logic [3:0] ST_LEVEL = 4'd11;
   localparam logic [3:0] ST_OUT   = 4'd12;

   localparam logic signed [SUM_BITS-1:0] SMAX = {1'b0, {(SUM_BITS-1){1'b1}}};
   localparam logic signed [SUM_BITS-1:0] SMIN = {1'b1, {(SUM_BITS-1){1'b0}}};
   localparam logic [63:0] ILIM = {2'b00, {62{1'b1}}};
   localparam logic [8:0]  STEP = 9'(MAX_STEP);
   // The accumulate must hold the integral plus a full err*dt product.
   localparam int WBITS = (SUM_BITS > 48) ? SUM_BITS + 1 : 49;

   logic [3:0]  state_ff, state_in;
   req_type     in_ff;
   logic signed [31:0] err_ff, err_in;
   logic signed [31:0] perr_ff;
   logic signed [SUM_BITS-1:0] sum_ff;
   logic [7:0]  plev_ff;
   logic        brake_ff;
   logic [63:0] smag_ff;
   logic signed [66:0] acc_ff;
   logic [80:0] ipart_ff;
   logic signed [63:0] pterm_ff, dterm_ff;
   logic        rsp_valid_ff;
   rsp_type     rsp_ff;

   // Shared multiplier: signed 34 x 17.
   logic signed [33:0] mul_a;
   logic signed [16:0] mul_b;
   logic signed [50:0] mul_p;
   logic signed [50:0] mul_ff;
   assign mul_p = mul_a * mul_b;

   div_req_type div_req;
   div_rsp_type div_rsp;

   jpsd_div u_div (.clock(clock), .reset(reset), .div_req(div_req), .div_rsp(div_rsp));

   logic signed [32:0] raw_err;
   logic signed [32:0] derr;
   logic [31:0] aerr;
   logic        cw, outside;
   logic [7:0]  lo, hi;
   logic signed [WBITS-1:0] sum_wide;
   logic signed [66:0] total;
   logic [66:0] tmag;
   logic [63:0] imag;
   logic [7:0]  lvl, lvl_c, lvl_s;
   logic [8:0]  up, dn;
   logic [1:0]  sg_e, sg_p;
   logic        hit;

   assign raw_err = 33'(in_ff.position) - 33'(in_ff.target);
   assign derr    = 33'(err_ff) - 33'(perr_ff);
   assign aerr    = err_ff[31] ? 32'(-33'(err_ff)) : 32'(err_ff);
   assign outside = aerr > {16'd0, cfg.tolerance};
   assign cw      = !err_ff[31] && (err_ff != 32'sd0);
   assign lo      = cw ? cfg.cw_floor : cfg.ccw_floor;
   assign hi      = cw ? cfg.cw_ceiling : cfg.ccw_ceiling;

   // Error saturation to 32 bits.
   always_comb begin
      if (raw_err > 33'sd2147483647)       err_in = 32'sh7fffffff;
      else if (raw_err < -33'sd2147483648) err_in = 32'sh80000000;
      else                                 err_in = raw_err[31:0];
   end

   // Multiplier operand selection per step.
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         ST_INC:  begin mul_a = 34'(err_ff); mul_b = {1'b0, in_ff.elapsed_ms}; end
         ST_PROP: begin mul_a = 34'(err_ff); mul_b = {1'b0, cfg.gain_prop}; end
         ST_ILO:  begin mul_a = {2'b00, smag_ff[31:0]}; mul_b = {1'b0, cfg.gain_integ}; end
         ST_IHI:  begin mul_a = {2'b00, smag_ff[63:32]}; mul_b = {1'b0, cfg.gain_integ}; end
         ST_DMUL: begin mul_a = 34'(derr); mul_b = {1'b0, cfg.gain_deriv}; end
         default: begin mul_a = '0; mul_b = '0; end
      endcase
   end

   // Saturating accumulate of the integral; mul_ff holds err*dt.
   always_comb begin
      sum_wide = WBITS'(sum_ff) + WBITS'(mul_ff);
   end

   // Integral term magnitude saturates at 2^62-1.
   assign imag = (ipart_ff[80:62] != 19'd0) ? ILIM : ipart_ff[63:0];

   assign total = 67'(pterm_ff) + 67'(dterm_ff) + (sum_ff[SUM_BITS-1] ? -67'(imag) : 67'(imag));
   assign tmag  = total[66] ? 67'(-total) : 67'(total);
   assign lvl   = (tmag[66:FRAC_BITS] > 55'd255) ? 8'd255 : tmag[FRAC_BITS+7:FRAC_BITS];

   function automatic logic [7:0] clampf(input logic [8:0] v, input logic [7:0] l,
                                        input logic [7:0] h);
      logic [8:0] t;
      begin
         t = (v > {1'b0, h}) ? {1'b0, h} : v;
         t = (t < {1'b0, l}) ? {1'b0, l} : t;
         return t[7:0];
      end
   endfunction

   // Clamp and slew limit; a change of the error sign forces the level to zero.
   always_comb begin
      lvl_c = clampf({1'b0, lvl}, lo, hi);
      sg_e  = err_ff[31] ? 2'b11 : (err_ff != 0 ? 2'b01 : 2'b00);
      sg_p  = perr_ff[31] ? 2'b11 : (perr_ff != 0 ? 2'b01 : 2'b00);
      up    = {1'b0, plev_ff} + STEP;
      dn    = {1'b0, plev_ff} - STEP;
      lvl_s = lvl_c;
      if (sg_e != sg_p) begin
         lvl_s = 8'd0;
      end else if (lvl_c > plev_ff) begin
         if ({1'b0, lvl_c} - {1'b0, plev_ff} > STEP) lvl_s = clampf(up, lo, hi);
      end else begin
         if ({1'b0, plev_ff} - {1'b0, lvl_c} > STEP) lvl_s = clampf(dn, lo, hi);
      end
      hit = cw ? in_ff.limit_fwd : in_ff.limit_rev;
   end

   always_comb begin
      div_req.start        = (state_ff == ST_DIV) && (in_ff.elapsed_ms != 16'd0);
      div_req.dividend_mag = acc_ff[63] ? 64'(-acc_ff) : acc_ff[63:0];
      div_req.divisor      = in_ff.elapsed_ms;
   end

   // Sequencer.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:  if (req.valid && !rsp_valid_ff) state_in = ST_ERR;
         ST_ERR:   state_in = ST_INC;
         ST_INC:   state_in = ST_SUM;
         ST_SUM:   state_in = ST_PROP;
         ST_PROP:  state_in = outside ? ST_ILO : ST_OUT;
         ST_ILO:   state_in = ST_IHI;
         ST_IHI:   state_in = ST_DMUL;
         ST_DMUL:  state_in = ST_DIV;
         ST_DIV:   state_in = (in_ff.elapsed_ms != 16'd0) ? ST_DWAIT : ST_TOTAL;
         ST_DWAIT: if (div_rsp.done) state_in = ST_TOTAL;
         ST_TOTAL: state_in = ST_LEVEL;
         ST_LEVEL: state_in = ST_IDLE;
         ST_OUT:   state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   assign req.ready = (state_ff == ST_IDLE) && !rsp_valid_ff;

   always_ff @(posedge clock) begin
      mul_ff <= mul_p;
      if (state_ff == ST_IDLE && req.valid && req.ready) in_ff <= req.data;
      if (state_ff == ST_ERR) err_ff <= err_in;
      if (state_ff == ST_PROP) pterm_ff <= 64'(mul_p);
      if (state_ff == ST_ILO) ipart_ff <= 81'(mul_p[47:0]);
      if (state_ff == ST_IHI) ipart_ff <= ipart_ff + {1'b0, mul_p[47:0], 32'd0};
      if (state_ff == ST_DMUL) acc_ff <= 67'(mul_p);
      if (state_ff == ST_DIV) dterm_ff <= '0;
      if (state_ff == ST_DWAIT && div_rsp.done)
         dterm_ff <= acc_ff[66] ? -64'(div_rsp.quotient) : 64'(div_rsp.quotient);
      if (reset) begin
         state_ff     <= ST_IDLE;
         perr_ff      <= '0;
         sum_ff       <= '0;
         plev_ff      <= '0;
         brake_ff     <= 1'b1;
         rsp_valid_ff <= 1'b0;
         smag_ff      <= '0;
      end else begin
         state_ff <= state_in;
         if (state_ff == ST_SUM) begin
            if (sum_wide > WBITS'(SMAX))      sum_ff <= SMAX;
            else if (sum_wide < WBITS'(SMIN)) sum_ff <= SMIN;
            else                              sum_ff <= sum_wide[SUM_BITS-1:0];
         end
         if (state_ff == ST_PROP)
            smag_ff <= sum_ff[SUM_BITS-1] ? 64'(-sum_ff) : 64'(sum_ff);
         if (rsp.valid && rsp.ready) rsp_valid_ff <= 1'b0;
         if (state_ff == ST_OUT) begin
            sum_ff   <= '0;
            brake_ff <= 1'b1;
            rsp_ff.drive_dir   <= DIR_STOP;
            rsp_ff.drive_level <= 8'd0;
            rsp_ff.brake_on    <= 1'b1;
            rsp_ff.settled     <= 1'b1;
            rsp_valid_ff       <= 1'b1;
         end
         if (state_ff == ST_LEVEL) begin
            perr_ff  <= err_ff;
            plev_ff  <= lvl_s;
            brake_ff <= hit;
            rsp_ff.drive_dir   <= hit ? DIR_STOP : (cw ? DIR_CW : DIR_CCW);
            rsp_ff.drive_level <= hit ? 8'd0 : lvl_s;
            rsp_ff.brake_on    <= hit;
            rsp_ff.settled     <= 1'b0;
            rsp_valid_ff       <= 1'b1;
         end
      end
   end

   assign rsp.valid = rsp_valid_ff;
   assign rsp.data  = rsp_ff;

   // A stopped drive never carries a level, and settling implies brake.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.drive_dir == DIR_STOP) |-> rsp_ff.drive_level == 8'd0)
      else $error("level driven while stopped");
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.settled) |-> rsp_ff.brake_on)
      else $error("settled without brake");
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> brake_ff == rsp_ff.brake_on)
      else $error("brake state mismatch");
   assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> !req.ready)
      else $error("ready while busy");

endmodule

FILE: rtl/joint_pid_slew_drive.sv
// Joint PID position controller with per-direction clamps and slew limit.
// Input channel (req_): position, target, elapsed_ms and the two limit
// switches; one transfer starts one control step. Result channel (rsp_):
// drive_dir, drive_level, brake_on and settled, one transfer per step.
// Configuration (csr_): APB-style port, registers at byte address 4*i; the user
// must write them only while the block is idle; the block does not enforce it.
// A step inside the tolerance runs ERR, INC, SUM, PROP and OUT. A step outside
// it runs ERR, INC, SUM, PROP, ILO, IHI, DMUL, DIV, DWAIT, TOTAL and LEVEL,
// waiting in DWAIT for the serial divider of the derivative term, which a zero
// elapsed_ms skips. The next transfer is accepted once the result is taken.
// The integral product uses the shared multiplier twice (low and high halves).
// One step is in work at a time; req_ready is low while busy or while a
// result waits on rsp_ready, so a stalled receiver holds the block.
// Reset restores the register defaults, clears the integral, previous error
// and level, and locks the brake.
module joint_pid_slew_drive
   import jpsd_pkg::*;
#(
   parameter int MAX_STEP = 15,
   parameter int SUM_BITS = 48
) (
   input  logic        clock,
   input  logic        reset,
   jpsd_req_if.sink    req,
   jpsd_rsp_if.source  rsp,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [4:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   cfg_type cfg;

   jpsd_csr u_csr (
      .clock(clock), .reset(reset),
      .psel(csr_psel), .penable(csr_penable), .pwrite(csr_pwrite),
      .paddr(csr_paddr), .pwdata(csr_pwdata), .prdata(csr_prdata),
      .pready(csr_pready), .cfg(cfg)
   );

   jpsd_core #(.MAX_STEP(MAX_STEP), .SUM_BITS(SUM_BITS)) u_core (
      .clock(clock), .reset(reset), .cfg(cfg), .req(req), .rsp(rsp)
   );

endmodule
